// ----- src/rx_command_packet_decoder_macros.svh -----
// Assertion macros for the command packet decoder.
// Included by rcpd_back, the module that carries concurrent checks; depends on nothing.
`ifndef RX_COMMAND_PACKET_DECODER_MACROS_SVH
`define RX_COMMAND_PACKET_DECODER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RCPD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rx_command_packet_decoder: assertion failed");

// Check a property on every clock edge, reset included.
`define RCPD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("rx_command_packet_decoder: assertion failed");

`endif

// ----- src/rcpd_pkg.sv -----
// Shared types, packet codes and key tables for the command packet decoder.
// Used by every module of the block; depends on nothing.
package rcpd_pkg;

    localparam int STORE_LEN   = 20;
    localparam int KEY_LEN     = 19;
    localparam int NAME_LEN    = 18;
    localparam int POS_W       = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] TYPE_CONNECT = 8'hA0;
    localparam logic [7:0] TYPE_NAME    = 8'hB1;
    localparam logic [7:0] TYPE_CLOCK   = 8'hC2;
    localparam logic [7:0] TYPE_ALARM   = 8'hD3;
    localparam logic [7:0] TYPE_VITALS  = 8'hE4;
    localparam logic [7:0] TYPE_LINK    = 8'hF5;
    localparam logic [7:0] ALARM_CANCEL = 8'd250;

    typedef logic [7:0] t_byte;

    localparam t_byte CONN_KEY [KEY_LEN] = '{
        8'hb6, 8'h91, 8'hdf, 8'h92, 8'h9a, 8'h92, 8'h90, 8'h8d, 8'h86, 8'hdf,
        8'h90, 8'h99, 8'hdf, 8'h92, 8'h86, 8'hdf, 8'h9e, 8'h88, 8'h8d};
    localparam t_byte LINK_KEY [KEY_LEN] = '{
        8'h96, 8'h87, 8'h9e, 8'hd1, 8'hab, 8'h97, 8'h9a, 8'hdf, 8'h93, 8'h90,
        8'h8c, 8'h8b, 8'hdf, 8'h97, 8'h9a, 8'h9e, 8'h8d, 8'h8b, 8'hd1};

    typedef enum logic [2:0] {
        CMD_CONNECT      = 3'd0,
        CMD_NAME         = 3'd1,
        CMD_CLOCK        = 3'd2,
        CMD_ALARM_CANCEL = 3'd3,
        CMD_ALARM_SET    = 3'd4,
        CMD_VITALS       = 3'd5,
        CMD_LINK         = 3'd6
    } t_cmd;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } t_back_state;

    // Decoded packet: bytes 1..19 kept as received.
    typedef struct packed {
        t_cmd               command;
        logic               key_ok;
        logic [3:0]         alarm_mask;
        logic [19:1][7:0]   data;
    } t_pkt;

    typedef struct packed {
        t_cmd               command;
        logic               key_ok;
        logic [6:0][7:0]    arg;
        logic [3:0]         alarm_mask;
        logic               last;
    } t_res;

endpackage

// ----- src/rcpd_front.sv -----
// Front end: collects packet bytes, checks keys on the fly and classifies packets.
// Depends on rcpd_pkg.
module rcpd_front import rcpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_packet_start,
    output logic        o_push,
    output t_pkt        o_pkt
);

    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_conn_ok, n_conn_ok;
    logic              r_link_ok, n_link_ok;
    t_byte             r_type;
    logic [19:1][7:0]  r_data;
    logic [POS_W-1:0]  key_idx;
    logic              conn_hit, link_hit;
    logic              known;
    logic              store_beat;

    assign key_idx  = r_pos - POS_W'(1);
    assign conn_hit = (i_rx_byte == CONN_KEY[key_idx]);
    assign link_hit = (i_rx_byte == LINK_KEY[key_idx]);

    always_comb begin
        known              = 1'b1;
        o_pkt.command      = CMD_CONNECT;
        o_pkt.key_ok       = 1'b0;
        o_pkt.alarm_mask   = 4'd0;
        o_pkt.data         = r_data;
        unique case (r_type)
            TYPE_CONNECT: begin
                o_pkt.key_ok = r_conn_ok;
            end
            TYPE_NAME:   o_pkt.command = CMD_NAME;
            TYPE_CLOCK:  o_pkt.command = CMD_CLOCK;
            TYPE_ALARM: begin
                if (r_data[1] == ALARM_CANCEL) begin
                    o_pkt.command = CMD_ALARM_CANCEL;
                end else begin
                    o_pkt.command    = CMD_ALARM_SET;
                    o_pkt.alarm_mask = {r_data[11] != 8'd0, r_data[10] != 8'd0,
                                        r_data[9] != 8'd0, r_data[8] != 8'd0};
                end
            end
            TYPE_VITALS: o_pkt.command = CMD_VITALS;
            TYPE_LINK: begin
                o_pkt.command = CMD_LINK;
                o_pkt.key_ok  = r_link_ok;
            end
            default:     known = 1'b0;
        endcase
    end

    always_comb begin
        n_pos      = r_pos;
        n_conn_ok  = r_conn_ok;
        n_link_ok  = r_link_ok;
        o_push     = 1'b0;
        store_beat = 1'b0;
        if (i_accept) begin
            if (i_packet_start) begin
                n_pos     = POS_W'(1);
                n_conn_ok = 1'b1;
                n_link_ok = 1'b1;
            end else if (r_pos != '0) begin
                if (r_pos < POS_W'(STORE_LEN)) begin
                    store_beat = 1'b1;
                    n_pos      = r_pos + POS_W'(1);
                    n_conn_ok  = r_conn_ok & conn_hit;
                    n_link_ok  = r_link_ok & link_hit;
                end else begin
                    // check beat: push only when the type is known and the byte repeats the type byte
                    n_pos  = '0;
                    o_push = known && (i_rx_byte == r_type);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_conn_ok <= 1'b0;
            r_link_ok <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_conn_ok <= n_conn_ok;
            r_link_ok <= n_link_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && i_packet_start) begin
            r_type <= i_rx_byte;
        end
        if (store_beat) begin
            r_data[r_pos] <= i_rx_byte;
        end
    end

endmodule

// ----- src/rcpd_fifo.sv -----
// Short queue of decoded packets between the front and back ends.
// Depends on rcpd_pkg.
module rcpd_fifo import rcpd_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_pkt  i_data,
    input  logic  i_pop,
    output t_pkt  o_data,
    output logic  o_full,
    output logic  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_pkt              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, n_wr;
    logic [PTR_W-1:0]  r_rd, n_rd;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- src/rcpd_back.sv -----
// Back end: expands each decoded packet into results and holds them in an output register.
// Depends on rcpd_pkg and rx_command_packet_decoder_macros.svh.
`include "rx_command_packet_decoder_macros.svh"

module rcpd_back import rcpd_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_pkt  i_data,
    input  logic  i_empty,
    output logic  o_pop,
    input  logic  i_pop,
    output logic  o_empty,
    output t_res  o_result
);

    t_back_state       r_state, n_state;
    logic [POS_W-1:0]  r_idx, n_idx;
    logic              r_oval, n_oval;
    t_pkt              r_cur;
    t_res              r_out;
    t_res              res;
    logic [POS_W-1:0]  name_sel;
    logic              load, emit;

    assign name_sel = r_idx + POS_W'(1);
    assign o_empty  = !r_oval;
    assign o_result = r_out;

    always_comb begin
        res            = '0;
        res.command    = r_cur.command;
        res.last       = 1'b1;
        unique case (r_cur.command) inside
            CMD_CONNECT, CMD_LINK: begin
                res.key_ok = r_cur.key_ok;
            end
            CMD_NAME: begin
                res.arg[0] = r_cur.data[name_sel];
                res.arg[1] = {3'd0, r_idx};
                res.arg[2] = r_cur.data[19];
                res.last   = (r_idx == POS_W'(NAME_LEN - 1));
            end
            CMD_CLOCK: begin
                res.arg[0] = r_cur.data[1];
                res.arg[1] = r_cur.data[2];
                res.arg[2] = r_cur.data[3];
                res.arg[3] = r_cur.data[4];
                res.arg[4] = r_cur.data[5];
                res.arg[5] = r_cur.data[6];
                res.arg[6] = r_cur.data[9];
            end
            CMD_ALARM_CANCEL: ;
            CMD_ALARM_SET: begin
                res.arg[0]     = r_cur.data[4];
                res.arg[1]     = r_cur.data[5];
                res.arg[2]     = r_cur.data[6];
                res.arg[3]     = r_cur.data[7];
                res.alarm_mask = r_cur.alarm_mask;
            end
            CMD_VITALS: begin
                res.arg[0] = r_cur.data[1];
                res.arg[1] = r_cur.data[2];
                res.arg[2] = r_cur.data[3];
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_oval  = r_oval;
        o_pop   = 1'b0;
        load    = 1'b0;
        emit    = 1'b0;
        if (r_oval && i_pop) begin
            n_oval = 1'b0;
        end
        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    load    = 1'b1;
                    n_idx   = '0;
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: begin
                // advance when the output register is free or being drained
                if (!r_oval || i_pop) begin
                    emit   = 1'b1;
                    n_oval = 1'b1;
                    if (res.last) begin
                        n_state = BK_IDLE;
                    end else begin
                        n_idx = r_idx + POS_W'(1);
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_idx   <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_oval  <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cur <= i_data;
        end
        if (emit) begin
            r_out <= res;
        end
    end

    `RCPD_ASSERT(a_idx_range, i_clk, i_rst_n, r_idx <= POS_W'(NAME_LEN - 1))
    `RCPD_ASSERT(a_single_last, i_clk, i_rst_n, r_oval && r_out.command != CMD_NAME |-> r_out.last)
    `RCPD_ASSERT(a_name_last, i_clk, i_rst_n,
        r_oval && r_out.command == CMD_NAME && r_out.last |-> r_out.arg[1] == 8'(NAME_LEN - 1))
    `RCPD_ASSERT(a_load_start, i_clk, i_rst_n, o_pop |=> r_state == BK_EMIT && r_idx == '0)

endmodule

// ----- src/rx_command_packet_decoder.sv -----
// Top level of the received command packet decoder: front end, packet queue, back end.
// Depends on rcpd_pkg, rcpd_front, rcpd_fifo and rcpd_back.
//
//   channel   handshake     fields
//   bytes in  push / full   i_rx_byte, i_packet_start
//   results   empty / pop   o_command, o_key_ok, o_arg0..o_arg6, o_alarm_mask, o_last
//
// One byte is taken per cycle while full is low; full is high while the packet queue
// holds QDEPTH decoded packets. A packet's results leave through the back end's output
// register; a name packet gives 18 results, one per cycle while pop drains them, paced
// by the back end's counter. Synchronous active-low reset clears byte position, queue, output valid.
module rx_command_packet_decoder import rcpd_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_packet_start,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_command,
    output logic        o_key_ok,
    output logic [7:0]  o_arg0,
    output logic [7:0]  o_arg1,
    output logic [7:0]  o_arg2,
    output logic [7:0]  o_arg3,
    output logic [7:0]  o_arg4,
    output logic [7:0]  o_arg5,
    output logic [7:0]  o_arg6,
    output logic [3:0]  o_alarm_mask,
    output logic        o_last
);

    logic  q_push, q_pop, q_empty;
    t_pkt  q_in, q_out;
    t_res  result;

    rcpd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (push && !full),
        .i_rx_byte      (i_rx_byte),
        .i_packet_start (i_packet_start),
        .o_push         (q_push),
        .o_pkt          (q_in)
    );

    rcpd_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_full  (full),
        .o_empty (q_empty)
    );

    rcpd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (q_out),
        .i_empty  (q_empty),
        .o_pop    (q_pop),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_result (result)
    );

    assign o_command    = result.command;
    assign o_key_ok     = result.key_ok;
    assign o_arg0       = result.arg[0];
    assign o_arg1       = result.arg[1];
    assign o_arg2       = result.arg[2];
    assign o_arg3       = result.arg[3];
    assign o_arg4       = result.arg[4];
    assign o_arg5       = result.arg[5];
    assign o_arg6       = result.arg[6];
    assign o_alarm_mask = result.alarm_mask;
    assign o_last       = result.last;

endmodule
